// ===== hdl/sahd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sahd_pkg
// Types and constants shared by the sensor alarm block: the sample and result
// beats, the register map and the register reset values.
// ----------------------------------------------------------------------------
package sahd_pkg;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_VIB_TRIP_LEVEL   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_CLEAR_LEVEL  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_TRIP_RUNS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_CLEAR_RUNS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIP_LEVEL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CLEAR_LEVEL = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_TRIP_LEVEL   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CLEAR_LEVEL  = 4'd7;

  // Register reset values.
  localparam logic signed [31:0] VIB_TRIP_LEVEL_RST  = 32'sd1000;
  localparam logic signed [31:0] VIB_CLEAR_LEVEL_RST = 32'sd500;
  localparam logic [7:0]         VIB_TRIP_RUNS_RST   = 8'd3;
  localparam logic [7:0]         VIB_CLEAR_RUNS_RST  = 8'd3;
  localparam logic [7:0]         TEMP_TRIP_RST       = 8'd40;
  localparam logic [7:0]         TEMP_CLEAR_RST      = 8'd35;
  localparam logic [7:0]         HUM_TRIP_RST        = 8'd80;
  localparam logic [7:0]         HUM_CLEAR_RST       = 8'd70;

  // One sample set.
  typedef struct packed {
    logic signed [31:0] vibration_level;
    logic [7:0]         temperature_reading;
    logic [7:0]         humidity_reading;
    logic               climate_sample_ok;
    logic               motion_sample_ok;
    logic               climate_sensor_failed;
    logic               motion_sensor_failed;
  } sahd_in_t;

  // One result.
  typedef struct packed {
    logic vib_alarm;
    logic temp_alarm;
    logic hum_alarm;
    logic sys_alarm;
  } sahd_out_t;

endpackage

// ===== hdl/sensor_alarm_hysteresis_debounce_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_alarm_hysteresis_debounce_top
// Vibration alarm with debounce run counters, and temperature and humidity
// alarms with plain hysteresis, combined into a system alarm.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-----------------------------
//  in_      | input     | in_valid / in_ready  | in_data (sahd_in_t)
//  out_     | output    | out_valid / out_ready| out_data (sahd_out_t)
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample beat is taken every cycle while in_ready is high. A beat goes to
// the input register, then to the result register, from which it is offered.
// Between them lie a signed compare and a saturating run count for vibration,
// and an unsigned compare per climate path. Reset (rst_n low, synchronous)
// clears alarms, run counters and stage valids and loads the register defaults.
// in_ready falls only while both stages hold a beat and out_ready is low.
// ----------------------------------------------------------------------------
module sensor_alarm_hysteresis_debounce_top
  import sahd_pkg::*;
#(
  parameter int RUN_COUNT_MAX = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sahd_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sahd_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(RUN_COUNT_MAX + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(RUN_COUNT_MAX);

  // Configuration registers.
  logic signed [31:0] vib_trip_level_r, vib_clear_level_r;
  logic [7:0]         vib_trip_runs_r, vib_clear_runs_r;
  logic [7:0]         temp_trip_r, temp_clear_r, hum_trip_r, hum_clear_r;

  // Pipeline registers.
  sahd_in_t  s1_r;
  logic      s1_valid_r, s1_valid_nxt;
  sahd_out_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  // Alarm state.
  logic             vib_alarm_r, vib_alarm_nxt;
  logic             temp_alarm_r, temp_alarm_nxt;
  logic             hum_alarm_r, hum_alarm_nxt;
  logic [CNT_W-1:0] high_cnt_r, high_cnt_nxt;
  logic [CNT_W-1:0] low_cnt_r, low_cnt_nxt;

  logic in_accept, advance;
  logic [CNT_W-1:0] high_inc, low_inc;

  // Handshake: the input stage moves on whenever the result register is free.
  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  // Saturating increments of the run counters.
  assign high_inc = (high_cnt_r < CNT_MAX) ? high_cnt_r + 1'b1 : high_cnt_r;
  assign low_inc  = (low_cnt_r < CNT_MAX) ? low_cnt_r + 1'b1 : low_cnt_r;

  // Vibration debounce, climate hysteresis and the combined result.
  always_comb begin
    vib_alarm_nxt  = vib_alarm_r;
    high_cnt_nxt   = high_cnt_r;
    low_cnt_nxt    = low_cnt_r;
    temp_alarm_nxt = temp_alarm_r;
    hum_alarm_nxt  = hum_alarm_r;

    if (s1_r.motion_sensor_failed) begin
      vib_alarm_nxt = 1'b0;
      high_cnt_nxt  = '0;
      low_cnt_nxt   = '0;
    end else if (!s1_r.motion_sample_ok) begin
      high_cnt_nxt = '0;
      low_cnt_nxt  = '0;
    end else if (!vib_alarm_r) begin
      low_cnt_nxt  = '0;
      high_cnt_nxt = (s1_r.vibration_level > vib_trip_level_r) ? high_inc : '0;
      if (CMP_W'(high_cnt_nxt) >= CMP_W'(vib_trip_runs_r)) begin
        vib_alarm_nxt = 1'b1;
        high_cnt_nxt  = '0;
      end
    end else begin
      high_cnt_nxt = '0;
      low_cnt_nxt  = (s1_r.vibration_level < vib_clear_level_r) ? low_inc : '0;
      if (CMP_W'(low_cnt_nxt) >= CMP_W'(vib_clear_runs_r)) begin
        vib_alarm_nxt = 1'b0;
        low_cnt_nxt   = '0;
      end
    end

    if (s1_r.climate_sensor_failed) begin
      temp_alarm_nxt = 1'b0;
      hum_alarm_nxt  = 1'b0;
    end else if (s1_r.climate_sample_ok) begin
      if (!temp_alarm_r) begin
        temp_alarm_nxt = (s1_r.temperature_reading >= temp_trip_r);
      end else begin
        temp_alarm_nxt = !(s1_r.temperature_reading <= temp_clear_r);
      end
      if (!hum_alarm_r) begin
        hum_alarm_nxt = (s1_r.humidity_reading >= hum_trip_r);
      end else begin
        hum_alarm_nxt = !(s1_r.humidity_reading <= hum_clear_r);
      end
    end

    out_nxt.vib_alarm  = vib_alarm_nxt;
    out_nxt.temp_alarm = temp_alarm_nxt;
    out_nxt.hum_alarm  = hum_alarm_nxt;
    out_nxt.sys_alarm  = vib_alarm_nxt || temp_alarm_nxt || hum_alarm_nxt ||
                         s1_r.climate_sensor_failed ||
                         s1_r.motion_sensor_failed;
  end

  // Control state and alarm state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      vib_alarm_r  <= 1'b0;
      temp_alarm_r <= 1'b0;
      hum_alarm_r  <= 1'b0;
      high_cnt_r   <= '0;
      low_cnt_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        vib_alarm_r  <= vib_alarm_nxt;
        temp_alarm_r <= temp_alarm_nxt;
        hum_alarm_r  <= hum_alarm_nxt;
        high_cnt_r   <= high_cnt_nxt;
        low_cnt_r    <= low_cnt_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // Configuration registers; an unmapped index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vib_trip_level_r  <= VIB_TRIP_LEVEL_RST;
      vib_clear_level_r <= VIB_CLEAR_LEVEL_RST;
      vib_trip_runs_r   <= VIB_TRIP_RUNS_RST;
      vib_clear_runs_r  <= VIB_CLEAR_RUNS_RST;
      temp_trip_r       <= TEMP_TRIP_RST;
      temp_clear_r      <= TEMP_CLEAR_RST;
      hum_trip_r        <= HUM_TRIP_RST;
      hum_clear_r       <= HUM_CLEAR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VIB_TRIP_LEVEL:   vib_trip_level_r  <= signed'(cfg_data);
        REG_VIB_CLEAR_LEVEL:  vib_clear_level_r <= signed'(cfg_data);
        REG_VIB_TRIP_RUNS:    vib_trip_runs_r   <= cfg_data[7:0];
        REG_VIB_CLEAR_RUNS:   vib_clear_runs_r  <= cfg_data[7:0];
        REG_TEMP_TRIP_LEVEL:  temp_trip_r       <= cfg_data[7:0];
        REG_TEMP_CLEAR_LEVEL: temp_clear_r      <= cfg_data[7:0];
        REG_HUM_TRIP_LEVEL:   hum_trip_r        <= cfg_data[7:0];
        REG_HUM_CLEAR_LEVEL:  hum_clear_r       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_alarm_hysteresis_debounce_top. A scoreboard
// class predicts the four alarm flags for every accepted sample beat and
// checks each result beat in order. Plain tasks drive the sample and register
// channels. The run has a directed opening and then several register settings
// with shaped random samples and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import sahd_pkg::*;

  localparam int RUN_COUNT_MAX = 255;
  localparam int CYCLE_LIMIT   = 400000;

  // Alarm prediction and in-order checking of result beats.
  class alarm_checker;
    logic signed [31:0] trip_lvl, clr_lvl;
    logic [7:0]         trip_runs, clr_runs, t_trip, t_clr, h_trip, h_clr;
    bit                 vib_al, temp_al, hum_al;
    logic [7:0]         high_run, low_run;
    sahd_out_t          expected_alarms[$];
    int                 errors;

    function new();
      trip_lvl  = VIB_TRIP_LEVEL_RST;
      clr_lvl   = VIB_CLEAR_LEVEL_RST;
      trip_runs = VIB_TRIP_RUNS_RST;
      clr_runs  = VIB_CLEAR_RUNS_RST;
      t_trip    = TEMP_TRIP_RST;
      t_clr     = TEMP_CLEAR_RST;
      h_trip    = HUM_TRIP_RST;
      h_clr     = HUM_CLEAR_RST;
      vib_al    = 1'b0;
      temp_al   = 1'b0;
      hum_al    = 1'b0;
      high_run  = '0;
      low_run   = '0;
      errors    = 0;
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    function int pending();
      return expected_alarms.size();
    endfunction

    // Register write; indexes outside the map are ignored.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_VIB_TRIP_LEVEL:   trip_lvl  = data;
        REG_VIB_CLEAR_LEVEL:  clr_lvl   = data;
        REG_VIB_TRIP_RUNS:    trip_runs = data[7:0];
        REG_VIB_CLEAR_RUNS:   clr_runs  = data[7:0];
        REG_TEMP_TRIP_LEVEL:  t_trip    = data[7:0];
        REG_TEMP_CLEAR_LEVEL: t_clr     = data[7:0];
        REG_HUM_TRIP_LEVEL:   h_trip    = data[7:0];
        REG_HUM_CLEAR_LEVEL:  h_clr     = data[7:0];
        default: ;
      endcase
    endfunction

    // Advance the alarm state by one accepted sample beat.
    function void take_sample(sahd_in_t s);
      logic signed [31:0] v;
      sahd_out_t          res;
      v = s.vibration_level;
      if (s.motion_sensor_failed) begin
        vib_al   = 1'b0;
        high_run = '0;
        low_run  = '0;
      end else if (!s.motion_sample_ok) begin
        high_run = '0;
        low_run  = '0;
      end else if (!vib_al) begin
        low_run = '0;
        if (v > trip_lvl)
          high_run = (high_run < RUN_COUNT_MAX) ? high_run + 8'd1 : high_run;
        else
          high_run = '0;
        if (high_run >= trip_runs) begin
          vib_al   = 1'b1;
          high_run = '0;
        end
      end else begin
        high_run = '0;
        if (v < clr_lvl)
          low_run = (low_run < RUN_COUNT_MAX) ? low_run + 8'd1 : low_run;
        else
          low_run = '0;
        if (low_run >= clr_runs) begin
          vib_al  = 1'b0;
          low_run = '0;
        end
      end

      // Climate alarms: plain hysteresis, cleared on a sensor failure.
      if (s.climate_sensor_failed) begin
        temp_al = 1'b0;
        hum_al  = 1'b0;
      end else if (s.climate_sample_ok) begin
        if (!temp_al) temp_al = (s.temperature_reading >= t_trip);
        else          temp_al = !(s.temperature_reading <= t_clr);
        if (!hum_al)  hum_al  = (s.humidity_reading >= h_trip);
        else          hum_al  = !(s.humidity_reading <= h_clr);
      end

      res.vib_alarm  = vib_al;
      res.temp_alarm = temp_al;
      res.hum_alarm  = hum_al;
      res.sys_alarm  = vib_al | temp_al | hum_al |
                       s.climate_sensor_failed | s.motion_sensor_failed;
      expected_alarms.push_back(res);
    endfunction

    task check_alarms(sahd_out_t got);
      sahd_out_t want;
      if (expected_alarms.size() == 0) begin
        report($sformatf("result beat %b with nothing expected", got));
      end else begin
        want = expected_alarms.pop_front();
        if (got.vib_alarm !== want.vib_alarm)
          report($sformatf("vib_alarm got %b want %b",
                           got.vib_alarm, want.vib_alarm));
        if (got.temp_alarm !== want.temp_alarm)
          report($sformatf("temp_alarm got %b want %b",
                           got.temp_alarm, want.temp_alarm));
        if (got.hum_alarm !== want.hum_alarm)
          report($sformatf("hum_alarm got %b want %b",
                           got.hum_alarm, want.hum_alarm));
        if (got.sys_alarm !== want.sys_alarm)
          report($sformatf("sys_alarm got %b want %b",
                           got.sys_alarm, want.sys_alarm));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sahd_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  sahd_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  alarm_checker sb;
  int           cycles = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           rx_hold    = 1'b0;
  bit           motion_noise = 1'b1;
  bit           trend;
  int           trend_left = 0;

  sensor_alarm_hysteresis_debounce_top #(
    .RUN_COUNT_MAX(RUN_COUNT_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Watch all three channels; everything is sampled at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)   sb.take_sample(in_data);
      if (out_valid && out_ready) sb.check_alarms(out_data);
    end
  end

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic sahd_in_t mk(int v, int t, int h, int cok, int mok, int cf, int mf);
    sahd_in_t s;
    s.vibration_level       = v;
    s.temperature_reading   = t[7:0];
    s.humidity_reading      = h[7:0];
    s.climate_sample_ok     = cok[0];
    s.motion_sample_ok      = mok[0];
    s.climate_sensor_failed = cf[0];
    s.motion_sensor_failed  = mf[0];
    return s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647)  return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // A byte close to one of two levels, or an extreme, or anything.
  function automatic logic [7:0] near_byte(logic [7:0] a, logic [7:0] b);
    int v;
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom);
      default: begin
        v = ($urandom_range(0, 1) ? int'(a) : int'(b)) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
      end
    endcase
  endfunction

  // Samples come in runs that sit above the trip level or below the clear
  // level, long enough for the debounce to complete about half the time.
  // Without motion noise the levels stay on the side of the run as well.
  function automatic sahd_in_t next_sample();
    sahd_in_t s;
    int       need;
    if (trend_left <= 0) begin
      trend      = 1'($urandom_range(0, 1));
      need       = trend ? int'(sb.trip_runs) : int'(sb.clr_runs);
      trend_left = 1 + ($urandom_range(0, 1) ? $urandom_range(need, need + 4)
                                             : $urandom_range(0, need + 1));
    end
    trend_left--;
    case ($urandom_range(0, 15))
      0:       s.vibration_level = 32'sh7FFFFFFF;
      1:       s.vibration_level = 32'sh80000000;
      2:       s.vibration_level = $urandom;
      3:       s.vibration_level = trend ? sb.trip_lvl : sb.clr_lvl;
      default: s.vibration_level = trend ?
                 clamp32(longint'(sb.trip_lvl) + longint'($urandom_range(1, 100))) :
                 clamp32(longint'(sb.clr_lvl) - longint'($urandom_range(1, 100)));
    endcase
    s.temperature_reading   = near_byte(sb.t_trip, sb.t_clr);
    s.humidity_reading      = near_byte(sb.h_trip, sb.h_clr);
    s.climate_sample_ok     = $urandom_range(0, 7) != 0;
    s.climate_sensor_failed = $urandom_range(0, 24) == 0;
    if (motion_noise) begin
      s.motion_sample_ok     = $urandom_range(0, 11) != 0;
      s.motion_sensor_failed = $urandom_range(0, 29) == 0;
    end else begin
      s.vibration_level      = trend ?
        clamp32(longint'(sb.trip_lvl) + longint'($urandom_range(1, 100))) :
        clamp32(longint'(sb.clr_lvl) - longint'($urandom_range(1, 100)));
      s.motion_sensor_failed = 1'b0;
      s.motion_sample_ok     = 1'b1;
    end
    return s;
  endfunction

  // One sample beat; valid is left high for a following beat.
  task send_sample(sahd_in_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task maybe_gap();
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop offering, let the monitor note the last accepted beat, wait for every
  // outstanding result, then let the two stages settle.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register map, plus one unmapped index.
  task program_regs(logic signed [31:0] tl, logic signed [31:0] cl,
                    logic [7:0] tr, logic [7:0] cr, logic [7:0] tt, logic [7:0] tc,
                    logic [7:0] ht, logic [7:0] hc);
    logic [31:0] junk;
    junk = $urandom & 32'hFFFF_FF00;
    write_reg(REG_VIB_TRIP_LEVEL,   tl);
    write_reg(REG_VIB_CLEAR_LEVEL,  cl);
    write_reg(REG_VIB_TRIP_RUNS,    {junk[31:8], tr});
    write_reg(REG_VIB_CLEAR_RUNS,   {junk[31:8], cr});
    write_reg(REG_TEMP_TRIP_LEVEL,  {junk[31:8], tt});
    write_reg(REG_TEMP_CLEAR_LEVEL, {junk[31:8], tc});
    write_reg(REG_HUM_TRIP_LEVEL,   {junk[31:8], ht});
    write_reg(REG_HUM_CLEAR_LEVEL,  {junk[31:8], hc});
    write_reg(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
    cfg_valid <= 1'b0;
  endtask

  task run_samples(int n, bit hold_midway);
    for (int i = 0; i < n; i++) begin
      maybe_gap();
      if (hold_midway && i == 10) rx_hold = 1'b1;
      send_sample(next_sample());
    end
  endtask

  // Main sequence.
  initial begin
    logic signed [31:0] lvl;
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening on the reset register values.
    send_sample(mk(0, 0, 0, 1, 1, 0, 0));
    send_sample(mk(32'sh7FFFFFFF, 255, 255, 1, 1, 0, 0));
    send_sample(mk(1001, 39, 79, 1, 1, 0, 0));
    send_sample(mk(1000, 0, 0, 0, 0, 0, 0));        // invalid motion, climate held
    send_sample(mk(1001, 35, 70, 1, 1, 0, 0));      // climate alarms fall at the level
    send_sample(mk(2000, 0, 0, 1, 1, 0, 0));
    maybe_gap();
    send_sample(mk(2000, 0, 0, 1, 1, 0, 0));        // third high sample raises
    send_sample(mk(32'sh80000000, 0, 0, 1, 1, 0, 0));
    send_sample(mk(499, 0, 0, 1, 1, 0, 0));
    send_sample(mk(500, 0, 0, 1, 1, 0, 0));         // at the clear level: run restarts
    send_sample(mk(-1, 0, 0, 1, 1, 0, 0));
    send_sample(mk(-1, 0, 0, 1, 0, 0, 0));          // invalid motion holds the alarm
    send_sample(mk(0, 0, 0, 1, 1, 0, 0));
    send_sample(mk(0, 0, 0, 1, 1, 0, 0));
    send_sample(mk(0, 0, 0, 1, 1, 0, 0));           // third low sample clears
    send_sample(mk(2000, 0, 0, 1, 1, 0, 0));
    send_sample(mk(2000, 0, 0, 1, 1, 0, 0));
    send_sample(mk(2000, 0, 0, 1, 1, 0, 0));
    send_sample(mk(2000, 50, 90, 1, 1, 0, 1));      // motion failure clears vibration
    send_sample(mk(0, 50, 90, 1, 1, 1, 0));         // climate failure clears both
    send_sample(mk(32'sh7FFFFFFF, 255, 255, 0, 0, 1, 1));
    send_sample(mk(0, 40, 80, 1, 1, 0, 0));         // trip exactly at the levels
    send_sample(mk(0, 0, 0, 0, 1, 0, 0));           // invalid climate holds
    drain();

    // Zero run lengths: every valid sample toggles the vibration alarm.
    program_regs($urandom, $urandom, 8'd0, 8'd0, 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
    run_samples(100, 1'b0);
    drain();

    // Level extremes: vibration can never exceed or fall below.
    program_regs(32'sh7FFFFFFF, 32'sh80000000, 8'd1, 8'd1, 8'd0, 8'd255,
                 8'd255, 8'd0);
    run_samples(80, 1'b0);
    drain();

    // Longest runs, with clean motion samples so that they can complete.
    motion_noise = 1'b0;
    program_regs(32'sd0, 32'sd0, 8'd255, 8'd255, 8'd128, 8'd127, 8'd200, 8'd10);
    run_samples(530, 1'b0);
    drain();
    motion_noise = 1'b1;

    // Random settings; one of them with a long hold-off on the result side.
    for (int p = 0; p < 4; p++) begin
      lvl = $urandom;
      program_regs(lvl, clamp32(longint'(lvl) - longint'($urandom_range(0, 5000))),
                   8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_samples(70, p == 1);
      drain();
    end

    // Back to the reset values, with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    program_regs(VIB_TRIP_LEVEL_RST, VIB_CLEAR_LEVEL_RST, VIB_TRIP_RUNS_RST,
                 VIB_CLEAR_RUNS_RST, TEMP_TRIP_RST, TEMP_CLEAR_RST, HUM_TRIP_RST,
                 HUM_CLEAR_RST);
    run_samples(120, 1'b0);
    drain();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sensor_alarm_hysteresis_debounce_top.f =====
hdl/sahd_pkg.sv
hdl/sensor_alarm_hysteresis_debounce_top.sv
sim/tb.sv
